// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`endif

// ===== hdl/hmre_pkg.sv =====
// shared constants, types and tables for the ht mcs rate estimator
// no dependencies
package hmre_pkg;

	// number of mcs indices looked at (8 to 32)
	localparam int McsCount = 32;
	localparam logic [32:0] McsMaskFull = (33'd1 << McsCount) - 33'd1;
	localparam logic [31:0] McsMask = McsMaskFull[31:0];

	localparam int RssiW = 9;
	localparam int BaseW = 24;
	localparam int FactorW = 6;
	localparam int RateW = 30;

	localparam logic signed [RssiW-1:0] WideMarginDb = 9'sd3;

	localparam logic [BaseW-1:0] Base20 = 24'd6500000;
	localparam logic [BaseW-1:0] Base20Sgi = 24'd7200000;
	localparam logic [BaseW-1:0] Base40 = 24'd13500000;
	localparam logic [BaseW-1:0] Base40Sgi = 24'd15000000;

	typedef struct packed {
		logic       found;
		logic [4:0] mcs;
	} sel_t;

	// minimum rssi for relative index mcs % 8
	function automatic logic signed [RssiW-1:0] rssi_threshold(input logic [2:0] rel);
		logic signed [RssiW-1:0] t;
		unique case (rel)
			3'd0: t = -9'sd82;
			3'd1: t = -9'sd79;
			3'd2: t = -9'sd77;
			3'd3: t = -9'sd74;
			3'd4: t = -9'sd70;
			3'd5: t = -9'sd66;
			3'd6: t = -9'sd65;
			default: t = -9'sd64;
		endcase
		return t;
	endfunction

	// streams times modulation multiplier for one mcs
	function automatic logic [FactorW-1:0] rate_factor(input logic [4:0] mcs);
		logic [3:0] mult;
		logic [FactorW-1:0] prod;
		unique case (mcs[2:0])
			3'd0: mult = 4'd1;
			3'd1: mult = 4'd2;
			3'd2: mult = 4'd3;
			3'd3: mult = 4'd4;
			3'd4: mult = 4'd6;
			3'd5: mult = 4'd8;
			3'd6: mult = 4'd9;
			3'd7: mult = 4'd10;
		endcase
		prod = {2'd0, mult} * ({4'd0, mcs[4:3]} + 6'd1);
		return prod;
	endfunction

endpackage

// ===== hdl/ht_mcs_rate_estimator.sv =====
// top level of the ht mcs rate estimator: three stage pipeline
// depends on hmre_pkg and hmre_select
//
//  channel | signals                                   | accepted when
//  --------+-------------------------------------------+----------------------
//  in      | in_valid in_ready cap_info_low            | in_valid & in_ready
//          | mcs_bitmap rssi_dbm                       |
//  out     | out_valid out_ready found chosen_mcs      | out_valid & out_ready
//          | rate_bps                                  |
//
// one item per cycle sustained while out_ready stays high; three register stages
// (threshold compare, priority select, rate multiply): an accepted item is
// registered in each stage in turn and out_valid is the stage 3 valid bit
// each stage moves on when it is empty or the stage after it moves, so a
// stalled output still lets earlier stages fill
// reset clears the stage valid bits only; data registers are not reset
module ht_mcs_rate_estimator import hmre_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          cap_info_low,
	input  logic [31:0]         mcs_bitmap,
	input  logic signed [7:0]   rssi_dbm,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                found,
	output logic [4:0]          chosen_mcs,
	output logic [RateW-1:0]    rate_bps
);

	// stage valid bits and advance enables
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	assign adv3 = !v_s3 || out_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	// stage 1: channel decode and per relative index rssi check
	logic        wide, sgi;
	logic [7:0]  pass;
	logic signed [RssiW-1:0] rssi_ext;

	assign wide = cap_info_low[1];
	assign sgi = wide ? cap_info_low[6] : cap_info_low[5];
	assign rssi_ext = {rssi_dbm[7], rssi_dbm};

	always_comb begin
		for (int r = 0; r < 8; r++) begin
			pass[r] = rssi_ext >= (rssi_threshold(3'(r)) + (wide ? WideMarginDb : 9'sd0));
		end
	end

	logic             wide_s1, sgi_s1;
	logic [7:0]       pass_s1;
	logic [31:0]      bitmap_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			wide_s1 <= wide;
			sgi_s1 <= sgi;
			pass_s1 <= pass;
			// bits above the supported mcs range are ignored
			bitmap_s1 <= mcs_bitmap & McsMask;
		end
	end

	// stage 2: pick highest eligible mcs, look up base rate and factor
	sel_t sel;

	hmre_select u_select (
		.bitmap (bitmap_s1),
		.pass   (pass_s1),
		.sel    (sel)
	);

	logic [BaseW-1:0] base;

	always_comb begin
		unique case ({wide_s1, sgi_s1})
			2'b00: base = Base20;
			2'b01: base = Base20Sgi;
			2'b10: base = Base40;
			default: base = Base40Sgi;
		endcase
	end

	sel_t               sel_s2;
	logic [BaseW-1:0]   base_s2;
	logic [FactorW-1:0] factor_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			sel_s2 <= sel;
			// zero base when nothing found so the rate comes out zero
			base_s2 <= sel.found ? base : '0;
			factor_s2 <= rate_factor(sel.mcs);
		end
	end

	// stage 3: rate multiply into the output register
	logic [BaseW+FactorW-1:0] prod;
	assign prod = {{FactorW{1'b0}}, base_s2} * {{BaseW{1'b0}}, factor_s2};

	sel_t             sel_s3;
	logic [RateW-1:0] rate_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			sel_s3 <= sel_s2;
			rate_s3 <= prod[RateW-1:0];
		end
	end

	assign out_valid = v_s3;
	assign found = sel_s3.found;
	assign chosen_mcs = sel_s3.mcs;
	assign rate_bps = rate_s3;

endmodule

// ===== hdl/hmre_select.sv =====
// priority select of the highest eligible mcs
// depends on hmre_pkg
module hmre_select import hmre_pkg::*; (
	input  logic [31:0] bitmap,
	input  logic [7:0]  pass,
	output sel_t        sel
);

	logic [31:0] elig;

	always_comb begin
		for (int i = 0; i < 32; i++) begin
			elig[i] = bitmap[i] & pass[i % 8];
		end
	end

	// highest set bit wins
	always_comb begin
		sel = '0;
		for (int i = 0; i < 32; i++) begin
			if (elig[i]) begin
				sel.found = 1'b1;
				sel.mcs = 5'(i);
			end
		end
	end

endmodule

// ===== hdl/hmre_checker.sv =====
// port level checks for the ht mcs rate estimator, bound to the top level
// depends on assert_macros.svh and ht_mcs_rate_estimator
`include "assert_macros.svh"

module hmre_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [4:0]  chosen_mcs,
	input logic [29:0] rate_bps
);

	// a stalled result holds
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(found) && $stable(chosen_mcs) && $stable(rate_bps), "stalled result changed")

	// a miss reports zero mcs and zero rate
	`ASSERT_NEVER(a_miss_zero, clk, arst_n, out_valid && !found && (chosen_mcs != 5'd0 || rate_bps != 30'd0), "miss with nonzero fields")

	// a hit always has a rate
	`ASSERT_NEVER(a_hit_rate, clk, arst_n, out_valid && found && rate_bps == 30'd0, "hit with zero rate")

	// rate never exceeds the top rate
	`ASSERT_NEVER(a_rate_max, clk, arst_n, out_valid && rate_bps > 30'd600000000, "rate above maximum")

endmodule

bind ht_mcs_rate_estimator hmre_checker u_hmre_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.found      (found),
	.chosen_mcs (chosen_mcs),
	.rate_bps   (rate_bps)
);

// ===== sim/tb_ht_mcs_rate_estimator.sv =====
// self-checking testbench for the ht mcs rate estimator top level
// depends on hmre_pkg and the ht_mcs_rate_estimator rtl, nothing else
module tb_ht_mcs_rate_estimator;
	import hmre_pkg::*;

	// run control
	localparam int RANDOM_ITEMS = 1450;
	localparam int STALL_LIMIT = 5000;   // cycles with no item moved on either side
	localparam int DRAIN_CYCLES = 8;     // pipeline is three deep, leave some slack

	// per-mcs rules of the rate table, indexed by mcs % 8
	localparam int RSSI_FLOOR [8] = '{-82, -79, -77, -74, -70, -66, -65, -64};
	localparam int MOD_MULT [8] = '{1, 2, 3, 4, 6, 8, 9, 10};
	localparam int WIDE_EXTRA_DB = 3;

	// what one item is expected to produce
	typedef struct {
		logic               found;
		logic [4:0]         mcs;
		logic [RateW-1:0]   rate;
	} rate_pick_t;

	// keeps the picks still owed by the block and compares the ones that come out
	class rate_pick_board;
		rate_pick_t picks_due[$];
		int errors = 0;

		// highest supported mcs that the signal can carry, and its data rate
		function rate_pick_t pick_mcs(input logic [7:0] cap, input logic [31:0] bm,
				input logic signed [7:0] rssi);
			rate_pick_t p;
			logic wide;
			logic sgi;
			longint base;
			longint rate;
			int floor_db;
			int top;
			p = '{found: 1'b0, mcs: '0, rate: '0};
			wide = cap[1];
			// the short guard bit moves with the channel width
			sgi = wide ? cap[6] : cap[5];
			if (wide)
				base = sgi ? 15000000 : 13500000;
			else
				base = sgi ? 7200000 : 6500000;
			top = (McsCount - 1 > 31) ? 31 : McsCount - 1;
			for (int i = top; i >= 0; i--) begin
				floor_db = RSSI_FLOOR[i % 8] + (wide ? WIDE_EXTRA_DB : 0);
				if (bm[i] && int'(rssi) >= floor_db) begin
					// base rate x streams x modulation factor
					rate = base * (i / 8 + 1) * MOD_MULT[i % 8];
					p.found = 1'b1;
					p.mcs = 5'(i);
					p.rate = rate[RateW-1:0];
					break;
				end
			end
			return p;
		endfunction

		function void note_item(input logic [7:0] cap, input logic [31:0] bm,
				input logic signed [7:0] rssi);
			picks_due.push_back(pick_mcs(cap, bm, rssi));
		endfunction

		task report_mismatch(input string msg);
			if (errors < 100)
				$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_pick(input logic f, input logic [4:0] m, input logic [RateW-1:0] r);
			rate_pick_t want;
			if (picks_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result found=%0b mcs=%0d rate=%0d",
					f, m, r));
				return;
			end
			want = picks_due.pop_front();
			if (f !== want.found)
				report_mismatch($sformatf("found %0b, want %0b", f, want.found));
			if (m !== want.mcs)
				report_mismatch($sformatf("chosen_mcs %0d, want %0d", m, want.mcs));
			if (r !== want.rate)
				report_mismatch($sformatf("rate_bps %0d, want %0d", r, want.rate));
		endtask
	endclass

	// block ports, all inputs known from time zero
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          cap_info_low = '0;
	logic [31:0]         mcs_bitmap = '0;
	logic signed [7:0]   rssi_dbm = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                found;
	logic [4:0]          chosen_mcs;
	logic [RateW-1:0]    rate_bps;

	// idle and stall chances in percent, changed per phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	rate_pick_board board = new();

	ht_mcs_rate_estimator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cap_info_low(cap_info_low),
		.mcs_bitmap  (mcs_bitmap),
		.rssi_dbm    (rssi_dbm),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.chosen_mcs  (chosen_mcs),
		.rate_bps    (rate_bps)
	);

	always #5 clk = ~clk;

	// receiver: stall at random, chance set by the current phase
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor both channels on the edge, with the values that stood before it
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_item(cap_info_low, mcs_bitmap, rssi_dbm);
			if (out_valid && out_ready)
				board.check_pick(found, chosen_mcs, rate_bps);
		end
	end

	// watchdog: too long with no item moving on either side ends the run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[ht_mcs_rate_estimator] ERROR");
			$finish;
		end
	end

	// offer one item and hold it until the block takes it
	// valid only drops when an idle gap is actually taken
	task send_item(input logic [7:0] cap, input logic [31:0] bm, input logic signed [7:0] rssi);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		cap_info_low <= cap;
		mcs_bitmap <= bm;
		rssi_dbm <= rssi;
		do @(posedge clk); while (!in_ready);
	endtask

	// corner items: base rate modes, nothing usable, rssi extremes and every threshold
	task run_directed();
		int rel;
		int mcs;
		// no supported mcs at all
		send_item(8'h00, 32'h0000_0000, 8'sd127);
		// everything supported, strong signal: mcs 31 in each width and guard mode
		send_item(8'h00, 32'hFFFF_FFFF, 8'sd127);
		send_item(8'h20, 32'hFFFF_FFFF, 8'sd127);
		send_item(8'h02, 32'hFFFF_FFFF, 8'sd127);
		send_item(8'h42, 32'hFFFF_FFFF, 8'sd127);
		// guard bit of the other width must be ignored
		send_item(8'h22, 32'hFFFF_FFFF, 8'sd127);
		send_item(8'h40, 32'hFFFF_FFFF, 8'sd127);
		// weakest signal: nothing passes
		send_item(8'hFF, 32'hFFFF_FFFF, -8'sd128);
		// each relative index alone at its exact floor (passes), and at 40 MHz two dB
		// above it, which the extra margin still leaves one dB short of enough
		for (rel = 0; rel < 8; rel++) begin
			mcs = rel + 8 * (rel % 4);
			send_item(8'h00, 32'd1 << mcs, 8'(RSSI_FLOOR[rel]));
			send_item(8'h02, 32'd1 << mcs, 8'(RSSI_FLOOR[rel] + WIDE_EXTRA_DB - 1));
		end
	endtask

	// random item: realistic bitmaps and signal levels mostly near the thresholds
	task send_random();
		logic [7:0] cap;
		logic [31:0] bm;
		logic signed [7:0] rssi;
		int k;
		cap = 8'($urandom_range(255));
		k = $urandom_range(31);
		case ($urandom_range(9))
			0, 1: bm = $urandom();
			2, 3: bm = $urandom() & $urandom() & $urandom();
			4, 5: bm = 32'((33'd1 << (k + 1)) - 33'd1);
			6: bm = 32'd1 << k;
			7: bm = {{8{$urandom_range(1) == 1}}, {8{$urandom_range(1) == 1}},
				{8{$urandom_range(1) == 1}}, {8{$urandom_range(1) == 1}}};
			8: bm = ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
			default: bm = ~($urandom() & $urandom());
		endcase
		// mostly around the thresholds, sometimes anywhere in range
		if ($urandom_range(9) < 8)
			rssi = 8'(int'($urandom_range(40)) - 90);
		else
			rssi = 8'($urandom_range(255));
		send_item(cap, bm, rssi);
	endtask

	task run_random_phase(input int count, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_random();
	endtask

	initial begin
		// single reset at the start
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		// idling phases: none, sender idle, receiver stalling, both
		run_random_phase(RANDOM_ITEMS / 4, 0, 0);
		run_random_phase(RANDOM_ITEMS / 4, 84, 0);
		run_random_phase(RANDOM_ITEMS / 4, 0, 84);
		run_random_phase(RANDOM_ITEMS - 3 * (RANDOM_ITEMS / 4), 19, 19);
		in_valid <= 1'b0;

		// drain everything owed, then let the pipeline settle
		while (board.picks_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.picks_due.size() != 0)
			board.report_mismatch($sformatf("%0d results never arrived",
				board.picks_due.size()));

		if (board.errors == 0)
			$display("[ht_mcs_rate_estimator] OK");
		else
			$display("[ht_mcs_rate_estimator] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/hmre_pkg.sv
hdl/hmre_select.sv
hdl/ht_mcs_rate_estimator.sv
hdl/hmre_checker.sv
sim/tb_ht_mcs_rate_estimator.sv
